// File: hdl/sample_channel_play_controller_defines.svh
// Assertion macros for the sample channel play controller.
`ifndef SAMPLE_CHANNEL_PLAY_CONTROLLER_DEFINES_SVH
`define SAMPLE_CHANNEL_PLAY_CONTROLLER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SCPC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scpc: same-cycle check failed");
`define SCPC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scpc: next-cycle check failed");
`else
`define SCPC_ASSERT_SAME(label, ante, cons)
`define SCPC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: hdl/scpc_pkg.sv
// Shared types, codes and helpers for the sample channel play controller.
`timescale 1ns / 1ps

package scpc_pkg;

  localparam int FRAME_W    = 12;
  localparam int CHAN_W     = 16;
  localparam int MODE_W     = 4;
  localparam int CODE_W     = 2;
  localparam int CMD_W      = 2;
  localparam int OP_W       = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Length of the sample buffer in frames; offsets beyond it are clamped.
  localparam int unsigned BUFFER_FRAMES = 32'd4096;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PLAY_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_CHANNEL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_CHAN_ID  = 2'd2;

  // Play modes that the event logic tells apart.
  localparam logic [MODE_W-1:0] MODE_RETRIG        = 4'd3;
  localparam logic [MODE_W-1:0] MODE_LOOP_ONCE     = 4'd6;
  localparam logic [MODE_W-1:0] MODE_LOOP_REPEAT   = 4'd7;
  localparam logic [MODE_W-1:0] MODE_LOOP_ONCE_BAR = 4'd8;

  typedef enum logic [OP_W-1:0] {
    OP_LAST_FRAME  = 3'd0,
    OP_FIRST_BEAT  = 3'd1,
    OP_BAR         = 3'd2,
    OP_REWIND      = 3'd3,
    OP_NOTE_ON     = 3'd4,
    OP_NOTE_OFF    = 3'd5,
    OP_NOTE_KILL   = 3'd6,
    OP_LOAD_STATUS = 3'd7
  } op_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_NONE   = 2'd0,
    CMD_NORMAL = 2'd1,
    CMD_REWIND = 2'd2,
    CMD_STOP   = 2'd3
  } cmd_t;

  // Status as it appears on the ports.
  typedef enum logic [CODE_W-1:0] {
    CODE_OFF    = 2'd0,
    CODE_PLAY   = 2'd1,
    CODE_WAIT   = 2'd2,
    CODE_ENDING = 2'd3
  } stat_code_t;

  // Status as it is held internally.
  typedef enum logic [3:0] {
    ST_OFF    = 4'b0001,
    ST_PLAY   = 4'b0010,
    ST_WAIT   = 4'b0100,
    ST_ENDING = 4'b1000
  } st_oh_t;

  typedef struct packed {
    op_t                opcode;
    logic [FRAME_W-1:0] frame_offset;
    logic [CHAN_W-1:0]  action_channel;
    logic               seq_running;
    logic               natural_end;
    stat_code_t         new_play_status;
    stat_code_t         new_rec_status;
  } evt_t;

  typedef struct packed {
    logic [MODE_W-1:0] play_mode;
    logic              loop_channel;
    logic [CHAN_W-1:0] own_channel_id;
  } cfg_t;

  typedef struct packed {
    st_oh_t play;
    st_oh_t rec;
    logic   act;
  } state_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [FRAME_W-1:0] frame;
    stat_code_t         play;
    stat_code_t         rec;
    logic               act;
  } res_t;

  function automatic st_oh_t oh_from_code(input stat_code_t code);
    st_oh_t st;
    case (code)
      CODE_OFF:    st = ST_OFF;
      CODE_PLAY:   st = ST_PLAY;
      CODE_WAIT:   st = ST_WAIT;
      CODE_ENDING: st = ST_ENDING;
      default:     st = ST_OFF;
    endcase
    return st;
  endfunction

  function automatic stat_code_t code_from_oh(input st_oh_t st);
    stat_code_t code;
    case (st)
      ST_OFF:    code = CODE_OFF;
      ST_PLAY:   code = CODE_PLAY;
      ST_WAIT:   code = CODE_WAIT;
      ST_ENDING: code = CODE_ENDING;
      default:   code = CODE_OFF;
    endcase
    return code;
  endfunction

endpackage

// File: hdl/scpc_in_if.sv
// Event channel: one event per transaction.
`timescale 1ns / 1ps

interface scpc_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [11:0] frame_offset;
  logic [15:0] action_channel;
  logic        seq_running;
  logic        natural_end;
  logic [1:0]  new_play_status;
  logic [1:0]  new_rec_status;

  modport source (
    output valid, opcode, frame_offset, action_channel, seq_running, natural_end,
           new_play_status, new_rec_status,
    input  ready
  );
  modport sink (
    input  valid, opcode, frame_offset, action_channel, seq_running, natural_end,
           new_play_status, new_rec_status,
    output ready
  );
endinterface

// File: hdl/scpc_out_if.sv
// Result channel: render command and status after each event.
`timescale 1ns / 1ps

interface scpc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  render_cmd;
  logic [11:0] render_frame;
  logic [1:0]  play_status;
  logic [1:0]  rec_status;
  logic        reading_actions;

  modport source (
    output valid, render_cmd, render_frame, play_status, rec_status, reading_actions,
    input  ready
  );
  modport sink (
    input  valid, render_cmd, render_frame, play_status, rec_status, reading_actions,
    output ready
  );
endinterface

// File: hdl/scpc_event_logic.sv
// Next-status and render-command logic for one event.
`timescale 1ns / 1ps

module scpc_event_logic (
  input  scpc_pkg::evt_t                 evt,
  input  scpc_pkg::cfg_t                 cfg,
  input  scpc_pkg::state_t               cur,
  output scpc_pkg::state_t               nxt,
  output scpc_pkg::cmd_t                 cmd,
  output logic [scpc_pkg::FRAME_W-1:0]   frame
);
  import scpc_pkg::*;

  localparam int unsigned LastFrame = BUFFER_FRAMES - 1;

  logic               loop_ch;
  logic               note_ok;
  logic               once_mode;
  logic [FRAME_W-1:0] f_sat;

  always_comb begin
    loop_ch   = cfg.loop_channel;
    note_ok   = !loop_ch && cur.act && (evt.action_channel == cfg.own_channel_id);
    once_mode = (cfg.play_mode == MODE_LOOP_ONCE) || (cfg.play_mode == MODE_LOOP_ONCE_BAR);

    if (32'(evt.frame_offset) >= BUFFER_FRAMES) begin
      f_sat = FRAME_W'(LastFrame);
    end else begin
      f_sat = evt.frame_offset;
    end

    nxt   = cur;
    cmd   = CMD_NONE;
    frame = '0;

    case (evt.opcode)
      OP_LAST_FRAME: begin
        if (cur.play == ST_PLAY) begin
          if (cfg.play_mode <= MODE_RETRIG || (loop_ch && !evt.seq_running) ||
              !evt.natural_end) begin
            nxt.play = ST_OFF;
          end else if (once_mode) begin
            nxt.play = ST_WAIT;
          end
        end else if (cur.play == ST_ENDING) begin
          nxt.play = ST_OFF;
        end
      end
      OP_FIRST_BEAT: begin
        if (cur.play == ST_PLAY) begin
          if (loop_ch) begin
            cmd   = CMD_REWIND;
            frame = f_sat;
          end
        end else if (cur.play == ST_WAIT) begin
          nxt.play = ST_PLAY;
          cmd      = CMD_NORMAL;
          frame    = f_sat;
        end else if (cur.play == ST_ENDING) begin
          if (loop_ch) begin
            cmd   = CMD_STOP;
            frame = f_sat;
          end
        end
        // Recording follows the first beat independently of playback.
        if (cur.rec == ST_WAIT) begin
          nxt.rec = ST_PLAY;
          nxt.act = 1'b1;
        end else if (cur.rec == ST_ENDING) begin
          nxt.rec = ST_OFF;
          nxt.act = 1'b0;
        end
      end
      OP_BAR: begin
        if (cur.play == ST_PLAY && (cfg.play_mode == MODE_LOOP_REPEAT ||
                                    cfg.play_mode == MODE_LOOP_ONCE_BAR)) begin
          cmd   = CMD_REWIND;
          frame = f_sat;
        end else if (cur.play == ST_WAIT && cfg.play_mode == MODE_LOOP_ONCE_BAR) begin
          nxt.play = ST_PLAY;
          cmd      = CMD_NORMAL;
          frame    = f_sat;
        end
      end
      OP_REWIND: begin
        if (loop_ch) begin
          cmd   = CMD_REWIND;
          frame = f_sat;
        end
      end
      OP_NOTE_ON: begin
        if (note_ok) begin
          if (cur.play == ST_OFF) begin
            nxt.play = ST_PLAY;
            cmd      = CMD_NORMAL;
            frame    = f_sat;
          end else if (cur.play == ST_PLAY) begin
            cmd   = (cfg.play_mode == MODE_RETRIG) ? CMD_REWIND : CMD_STOP;
            frame = f_sat;
          end
        end
      end
      OP_NOTE_OFF, OP_NOTE_KILL: begin
        if (note_ok && cur.play == ST_PLAY) begin
          cmd   = CMD_STOP;
          frame = f_sat;
        end
      end
      OP_LOAD_STATUS: begin
        nxt.play = oh_from_code(evt.new_play_status);
        nxt.rec  = oh_from_code(evt.new_rec_status);
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

// File: hdl/sample_channel_play_controller.sv
// Top level of the sample channel play controller.
`timescale 1ns / 1ps
`include "sample_channel_play_controller_defines.svh"

// Takes one event per clock cycle and returns exactly one result per event. The event
// is captured in an input register, and the status update is worked out in a single
// pass and written with the new status into the result register, which drives out_res.
// The event throughput is one per cycle as long as results are taken; a held result
// stalls the input register, and in_evt.ready then falls.
// Configuration writes take effect on the next clock edge and must be made while no
// event is in flight.
module sample_channel_play_controller (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [scpc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [scpc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  scpc_in_if.sink                            in_evt,
  scpc_out_if.source                         out_res
);
  import scpc_pkg::*;

  cfg_t   cfg_r;
  evt_t   evt_in;
  evt_t   s1_evt_r;
  logic   s1_v_r;
  logic   out_v_r;
  res_t   out_pl_r;
  res_t   res_nxt;
  state_t st_r;
  state_t st_nxt;
  cmd_t   cmd_nxt;
  logic [FRAME_W-1:0] frame_nxt;
  logic   out_adv;
  logic   in_acc;
  logic   s2_fire;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PLAY_MODE:    cfg_r.play_mode      <= cfg_wdata[MODE_W-1:0];
        CFG_LOOP_CHANNEL: cfg_r.loop_channel   <= cfg_wdata[0];
        CFG_OWN_CHAN_ID:  cfg_r.own_channel_id <= cfg_wdata[CHAN_W-1:0];
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  // The result register advances when it is empty or its content is taken.
  assign out_adv      = !out_v_r || out_res.ready;
  assign in_evt.ready = !s1_v_r || out_adv;
  assign in_acc       = in_evt.valid && in_evt.ready;
  assign s2_fire      = s1_v_r && out_adv;

  always_comb begin
    evt_in.opcode          = op_t'(in_evt.opcode);
    evt_in.frame_offset    = in_evt.frame_offset;
    evt_in.action_channel  = in_evt.action_channel;
    evt_in.seq_running     = in_evt.seq_running;
    evt_in.natural_end     = in_evt.natural_end;
    evt_in.new_play_status = stat_code_t'(in_evt.new_play_status);
    evt_in.new_rec_status  = stat_code_t'(in_evt.new_rec_status);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_evt.ready) begin
      s1_v_r <= in_evt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_evt_r <= evt_in;
    end
  end

  scpc_event_logic u_event_logic (
    .evt   (s1_evt_r),
    .cfg   (cfg_r),
    .cur   (st_r),
    .nxt   (st_nxt),
    .cmd   (cmd_nxt),
    .frame (frame_nxt)
  );

  always_comb begin
    res_nxt.cmd   = cmd_nxt;
    res_nxt.frame = frame_nxt;
    res_nxt.play  = code_from_oh(st_nxt.play);
    res_nxt.rec   = code_from_oh(st_nxt.rec);
    res_nxt.act   = st_nxt.act;
  end

  // Status is committed together with the result that reports it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= '{play: ST_OFF, rec: ST_OFF, act: 1'b0};
      out_v_r <= 1'b0;
    end else begin
      if (s2_fire) begin
        st_r <= st_nxt;
      end
      if (out_adv) begin
        out_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      out_pl_r <= res_nxt;
    end
  end

  assign out_res.valid           = out_v_r;
  assign out_res.render_cmd      = out_pl_r.cmd;
  assign out_res.render_frame    = out_pl_r.frame;
  assign out_res.play_status     = out_pl_r.play;
  assign out_res.rec_status      = out_pl_r.rec;
  assign out_res.reading_actions = out_pl_r.act;

  `SCPC_ASSERT_NEXT(a_stall_holds_state, out_v_r && !out_res.ready, $stable(st_r))
  `SCPC_ASSERT_NEXT(a_accept_fills_stage, in_acc, s1_v_r)
  `SCPC_ASSERT_SAME(a_result_matches_state, out_v_r,
                    out_pl_r.act == st_r.act && out_pl_r.play == code_from_oh(st_r.play))
  `SCPC_ASSERT_SAME(a_no_cmd_zero_frame, out_v_r && out_pl_r.cmd == CMD_NONE, out_pl_r.frame == '0)

endmodule
